/* rtl/touch_spi_sampler_calibrated_macros.svh */
// assertion macros for the touch sampler rtl
// no dependencies; files that check their own logic include this header
`ifndef TOUCH_SPI_SAMPLER_CALIBRATED_MACROS_SVH
`define TOUCH_SPI_SAMPLER_CALIBRATED_MACROS_SVH

`ifndef SYNTH

// property holds at every clock edge out of reset
`define TSC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("tsc assertion failed");

// condition a implies condition b at the next clock
`define TSC_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
    else $error("tsc assertion failed");

`else

`define TSC_ASSERT(lbl, clk, rstn, prop)
`define TSC_ASSERT_NEXT(lbl, clk, rstn, a, b)

`endif

`endif

/* rtl/tsc_pkg.sv */
// shared types and constants of the touch sampler
// used by tsc_seq, tsc_map and touch_spi_sampler_calibrated
package tsc_pkg;

  localparam int unsigned REG_W           = 12;
  localparam int unsigned CMD_BITS        = 8;
  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned CFG_IDX_W       = 3;

  localparam logic [CMD_BITS-1:0] CMD_X = 8'hD0;
  localparam logic [CMD_BITS-1:0] CMD_Y = 8'h90;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd5;

  localparam logic [REG_W-1:0] RST_X_MIN  = 12'd0;
  localparam logic [REG_W-1:0] RST_Y_MIN  = 12'd0;
  localparam logic [REG_W-1:0] RST_X_MAX  = 12'd4095;
  localparam logic [REG_W-1:0] RST_Y_MAX  = 12'd4095;
  localparam logic [REG_W-1:0] RST_WIDTH  = 12'd320;
  localparam logic [REG_W-1:0] RST_HEIGHT = 12'd240;

  // result tdata bit positions
  localparam int unsigned OUT_CS    = 0;
  localparam int unsigned OUT_SCLK  = 1;
  localparam int unsigned OUT_MOSI  = 2;
  localparam int unsigned OUT_DONE  = 3;
  localparam int unsigned OUT_X_LO  = 4;
  localparam int unsigned OUT_Y_LO  = 16;
  localparam int unsigned OUT_FAULT = 28;
  localparam int unsigned OUT_W     = 32;

  // pin levels of one half period, plus end-of-sample mark
  typedef struct packed {
    logic cs_n;
    logic sclk;
    logic mosi;
    logic finish;
  } seq_out_t;

endpackage

/* rtl/touch_spi_sampler_calibrated.sv */
// touch sampler top level: item handshake, calibration registers, result register
// depends on tsc_pkg, tsc_seq, tsc_map and touch_spi_sampler_calibrated_macros.svh
//
// usage
//   each input item on s_axis is one half period of the serial clock:
//   tdata bit 0 is start_req, bit 1 the sampled miso level. every item gives
//   exactly one result item on m_axis with the pin levels for that half period
//   (cs_n, sclk, mosi), the done flag and the last mapped coordinates.
//   a sample runs an x transfer (command 0xd0) then a y transfer (command 0x90),
//   8 command bits out and SAMPLE_BITS result bits in, two items per bit.
// latency and throughput
//   an ordinary item's result is registered and shows the next cycle, so one
//   item per cycle while the result is taken and no map pass runs.
//   the final item of a sample runs the serial map unit twice (x then y); each
//   pass runs a setup step, the shift-add multiply, the restoring divide and a
//   done step, and that result is registered once the y pass is done.
//   a zero span skips the arithmetic and gives 0 with cal_fault set.
// reset and stall
//   reset puts the calibration registers at their defaults, the sequencer idle
//   with chip select high and the coordinates at zero. while a result waits
//   with m_axis_tready low, at most one item is held and no new one is taken.
//   the configuration channel is always ready; write it only while idle.
module touch_spi_sampler_calibrated #(
  parameter int unsigned SAMPLE_BITS = tsc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input items
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // start_req, miso, zero fill
  // result items
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [tsc_pkg::OUT_W-1:0]    m_axis_tdata,  // cs_n, sclk, mosi, done_res,
                                                      // touch_x, touch_y, cal_fault,
                                                      // zero fill
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tsc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tsc_pkg::REG_W-1:0]    cfg_data_i
);
  import tsc_pkg::*;

`include "touch_spi_sampler_calibrated_macros.svh"

  // raw values are at least register width for the map arithmetic
  localparam int unsigned RAW_W = (SAMPLE_BITS > REG_W) ? SAMPLE_BITS : REG_W;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_MAPX,
    ST_MAPY
  } top_state_e;

  // calibration registers
  logic [REG_W-1:0] x_min_q, y_min_q, x_max_q, y_max_q, width_q, height_q;

  top_state_e        st_q;
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q;
  logic [REG_W-1:0]  last_x_q, last_y_q;
  logic              fault_q;
  logic              map_start_q;
  logic              map_axis_q;

  logic              in_acc;
  seq_out_t          pins;
  logic [SAMPLE_BITS-1:0] raw_x, raw_y;

  logic              map_done;
  logic [REG_W-1:0]  map_res;
  logic              map_fault;
  logic [RAW_W-1:0]  map_raw;
  logic [REG_W-1:0]  map_lo, map_hi, map_size;

  // result words: levels of an accepted item, and the finished sample
  logic [OUT_W-1:0]  run_word;
  logic [OUT_W-1:0]  done_word;

  // items are taken only while no map pass runs and the result slot frees up
  assign s_axis_tready = (st_q == ST_RUN) && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  tsc_seq #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_acc),
    .start_i(s_axis_tdata[0]),
    .miso_i (s_axis_tdata[1]),
    .pins_o (pins),
    .raw_x_o(raw_x),
    .raw_y_o(raw_y)
  );

  // one map unit serves both axes in turn
  always_comb begin
    if (map_axis_q) begin
      map_raw  = RAW_W'(raw_y);
      map_lo   = y_min_q;
      map_hi   = y_max_q;
      map_size = height_q;
    end else begin
      map_raw  = RAW_W'(raw_x);
      map_lo   = x_min_q;
      map_hi   = x_max_q;
      map_size = width_q;
    end
  end

  tsc_map #(
    .RAW_W(RAW_W)
  ) u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(map_start_q),
    .raw_i  (map_raw),
    .lo_i   (map_lo),
    .hi_i   (map_hi),
    .size_i (map_size),
    .done_o (map_done),
    .res_o  (map_res),
    .fault_o(map_fault)
  );

  always_comb begin
    run_word                      = '0;
    run_word[OUT_CS]              = pins.cs_n;
    run_word[OUT_SCLK]            = pins.sclk;
    run_word[OUT_MOSI]            = pins.mosi;
    run_word[OUT_DONE]            = pins.finish;
    run_word[OUT_X_LO +: REG_W]   = last_x_q;
    run_word[OUT_Y_LO +: REG_W]   = last_y_q;

    // done item levels are already held, only the coordinates and fault change
    done_word                     = out_data_q;
    done_word[OUT_X_LO +: REG_W]  = last_x_q;
    done_word[OUT_Y_LO +: REG_W]  = map_res;
    done_word[OUT_FAULT]          = fault_q | map_fault;
  end

  // configuration register file, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q  <= RST_X_MIN;
      y_min_q  <= RST_Y_MIN;
      x_max_q  <= RST_X_MAX;
      y_max_q  <= RST_Y_MAX;
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_X_MIN:  x_min_q  <= cfg_data_i;
        REG_Y_MIN:  y_min_q  <= cfg_data_i;
        REG_X_MAX:  x_max_q  <= cfg_data_i;
        REG_Y_MAX:  y_max_q  <= cfg_data_i;
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_RUN;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      fault_q     <= 1'b0;
      map_start_q <= 1'b0;
      map_axis_q  <= 1'b0;
    end else begin
      unique case (st_q)
        ST_RUN: begin
          if (in_acc) begin
            out_data_q  <= run_word;
            // hold the result back until both axes are mapped
            out_valid_q <= !pins.finish;
            map_start_q <= pins.finish;
            if (pins.finish) begin
              map_axis_q <= 1'b0;
              st_q       <= ST_MAPX;
            end
          end else begin
            map_start_q <= 1'b0;
            if (m_axis_tready) begin
              out_valid_q <= 1'b0;
            end
          end
        end
        ST_MAPX: begin
          map_start_q <= map_done;
          if (map_done) begin
            last_x_q   <= map_res;
            fault_q    <= map_fault;
            map_axis_q <= 1'b1;
            st_q       <= ST_MAPY;
          end
        end
        ST_MAPY: begin
          map_start_q <= 1'b0;
          if (map_done) begin
            last_y_q    <= map_res;
            out_data_q  <= done_word;
            out_valid_q <= 1'b1;
            st_q        <= ST_RUN;
          end
        end
        default: begin
          map_start_q <= 1'b0;
          st_q        <= ST_RUN;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // no result is offered while a map pass runs
  `TSC_ASSERT(a_no_out_in_map, clk_i, rst_ni, (st_q == ST_RUN) || !out_valid_q)
  // the map unit finishes only when a pass was asked for
  `TSC_ASSERT(a_map_done_in_map, clk_i, rst_ni,
              !map_done || (st_q == ST_MAPX) || (st_q == ST_MAPY))
  // the final item of a sample always starts the x pass
  `TSC_ASSERT_NEXT(a_finish_starts_map, clk_i, rst_ni, in_acc && pins.finish,
                   (st_q == ST_MAPX) && map_start_q && !map_axis_q)
  // a done result is a busy low half period
  `TSC_ASSERT(a_done_levels, clk_i, rst_ni,
              !(out_valid_q && out_data_q[OUT_DONE]) ||
              (!out_data_q[OUT_CS] && !out_data_q[OUT_SCLK]))

endmodule

/* rtl/tsc_seq.sv */
// serial transfer sequencer: command shift-out and sample shift-in
// depends on tsc_pkg
module tsc_seq #(
  parameter int unsigned SAMPLE_BITS = tsc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   start_i,
  input  logic                   miso_i,
  output tsc_pkg::seq_out_t      pins_o,
  output logic [SAMPLE_BITS-1:0] raw_x_o,
  output logic [SAMPLE_BITS-1:0] raw_y_o
);
  import tsc_pkg::*;

  localparam int unsigned LAST_CNT = CMD_BITS + SAMPLE_BITS;
  localparam int unsigned CW       = $clog2(LAST_CNT + 1);

  logic                   busy_q, busy_d;
  logic                   phase_q, phase_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   axis_q, axis_d;
  logic [CMD_BITS-1:0]    cmd_q, cmd_d;
  logic [SAMPLE_BITS-1:0] shift_q, shift_d;
  logic [SAMPLE_BITS-1:0] raw_x_q, raw_x_d;

  // view of the state as this item sees it, with a fresh start folded in
  logic                   run;
  logic                   cur_phase;
  logic [CW-1:0]          cur_cnt;
  logic                   cur_axis;
  logic [CMD_BITS-1:0]    cur_cmd;
  logic [SAMPLE_BITS-1:0] cur_shift;
  logic [CW-1:0]          cnt_inc;
  logic                   last_bit;

  always_comb begin
    run       = busy_q | start_i;
    cur_phase = busy_q ? phase_q : 1'b0;
    cur_cnt   = busy_q ? cnt_q : '0;
    cur_axis  = busy_q ? axis_q : 1'b0;
    cur_cmd   = busy_q ? cmd_q : CMD_X;
    cur_shift = busy_q ? shift_q : '0;
    cnt_inc   = cur_cnt + 1'b1;
    last_bit  = (cnt_inc == CW'(LAST_CNT));

    busy_d  = busy_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    axis_d  = axis_q;
    cmd_d   = cmd_q;
    shift_d = shift_q;
    raw_x_d = raw_x_q;

    pins_o.cs_n   = ~run;
    pins_o.sclk   = run & ~cur_phase;
    pins_o.mosi   = run & cur_cmd[CMD_BITS-1];
    pins_o.finish = 1'b0;

    if (run) begin
      busy_d  = 1'b1;
      phase_d = cur_phase;
      cnt_d   = cur_cnt;
      axis_d  = cur_axis;
      cmd_d   = cur_cmd;
      shift_d = cur_shift;
      if (!cur_phase) begin
        // clock high half: sample the data line once past the command
        if (cur_cnt >= CW'(CMD_BITS)) begin
          shift_d = {cur_shift[SAMPLE_BITS-2:0], miso_i};
        end
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
        cnt_d   = cnt_inc;
        cmd_d   = {cur_cmd[CMD_BITS-2:0], 1'b0};
        if (last_bit) begin
          cnt_d = '0;
          if (!cur_axis) begin
            raw_x_d = cur_shift;
            axis_d  = 1'b1;
            shift_d = '0;
            cmd_d   = CMD_Y;
          end else begin
            busy_d        = 1'b0;
            axis_d        = 1'b0;
            pins_o.finish = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
      axis_q  <= 1'b0;
      cmd_q   <= CMD_X;
      shift_q <= '0;
      raw_x_q <= '0;
    end else if (step_i) begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
      cmd_q   <= cmd_d;
      shift_q <= shift_d;
      raw_x_q <= raw_x_d;
    end
  end

  assign raw_x_o = raw_x_q;
  assign raw_y_o = shift_q;

endmodule

/* rtl/tsc_map.sv */
// linear calibration map: shift-add multiply then restoring divide, one bit a cycle
// depends on tsc_pkg
module tsc_map #(
  parameter int unsigned RAW_W = tsc_pkg::REG_W
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [RAW_W-1:0]          raw_i,
  input  logic [tsc_pkg::REG_W-1:0] lo_i,
  input  logic [tsc_pkg::REG_W-1:0] hi_i,
  input  logic [tsc_pkg::REG_W-1:0] size_i,
  output logic                      done_o,
  output logic [tsc_pkg::REG_W-1:0] res_o,
  output logic                      fault_o
);
  import tsc_pkg::*;

  localparam int unsigned PW = RAW_W + REG_W;
  localparam int unsigned CW = $clog2(PW + 1);

  typedef enum logic [1:0] {
    M_IDLE,
    M_MUL,
    M_DIV,
    M_DONE
  } map_state_e;

  map_state_e       st_q;
  logic [CW-1:0]    cnt_q;
  logic [RAW_W-1:0] mag_q;
  logic             neg_q;
  logic [REG_W-1:0] span_q;
  logic [REG_W-1:0] size_q;
  logic [REG_W-1:0] mlt_q;
  logic [PW-1:0]    acc_q;
  logic [REG_W-1:0] rem_q;
  logic [REG_W-1:0] res_q;
  logic             fault_q;

  logic [RAW_W-1:0] lo_ext;
  logic             raw_below;
  logic [RAW_W-1:0] mag_d;
  logic [REG_W-1:0] span_d;
  logic [PW-1:0]    mul_d;
  logic [REG_W:0]   rem_sh;
  logic             ge;
  logic [REG_W:0]   rem_sub;
  logic [PW-1:0]    quo_d;
  logic [REG_W-1:0] clamp_d;

  always_comb begin
    lo_ext    = RAW_W'(lo_i);
    raw_below = raw_i < lo_ext;
    mag_d     = raw_below ? (lo_ext - raw_i) : (raw_i - lo_ext);
    span_d    = (hi_i < lo_i) ? (lo_i - hi_i) : (hi_i - lo_i);

    mul_d = {acc_q[PW-2:0], 1'b0} + (mlt_q[REG_W-1] ? PW'(mag_q) : '0);

    rem_sh  = {rem_q, acc_q[PW-1]};
    ge      = rem_sh >= {1'b0, span_q};
    rem_sub = rem_sh - {1'b0, span_q};
    quo_d   = {acc_q[PW-2:0], ge};

    // quotient of opposite signs is never positive, so it clamps to zero
    if (neg_q) begin
      clamp_d = '0;
    end else if (quo_d > PW'(size_q)) begin
      clamp_d = size_q;
    end else begin
      clamp_d = quo_d[REG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= M_IDLE;
      cnt_q   <= '0;
      res_q   <= '0;
      fault_q <= 1'b0;
    end else begin
      unique case (st_q)
        M_IDLE: begin
          if (start_i) begin
            mag_q  <= mag_d;
            neg_q  <= raw_below ^ (hi_i < lo_i);
            span_q <= span_d;
            size_q <= size_i;
            mlt_q  <= size_i;
            acc_q  <= '0;
            cnt_q  <= '0;
            if (span_d == '0) begin
              res_q   <= '0;
              fault_q <= 1'b1;
              st_q    <= M_DONE;
            end else begin
              fault_q <= 1'b0;
              st_q    <= M_MUL;
            end
          end
        end
        M_MUL: begin
          acc_q <= mul_d;
          mlt_q <= {mlt_q[REG_W-2:0], 1'b0};
          if (cnt_q == CW'(REG_W - 1)) begin
            cnt_q <= '0;
            rem_q <= '0;
            st_q  <= M_DIV;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        M_DIV: begin
          acc_q <= quo_d;
          rem_q <= ge ? rem_sub[REG_W-1:0] : rem_sh[REG_W-1:0];
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(PW - 1)) begin
            res_q <= clamp_d;
            st_q  <= M_DONE;
          end
        end
        M_DONE: begin
          st_q <= M_IDLE;
        end
        default: begin
          st_q <= M_IDLE;
        end
      endcase
    end
  end

  assign done_o  = (st_q == M_DONE);
  assign res_o   = res_q;
  assign fault_o = fault_q;

endmodule

/* tb/testbench.sv */
// self-checking testbench for the touch sampler with calibration map
// needs tsc_pkg and the touch_spi_sampler_calibrated rtl; holds its own prediction
`timescale 1ns / 100ps

module testbench;
  import tsc_pkg::*;

  localparam int SMP_BITS     = SAMPLE_BITS_DEF;
  localparam int XFER_ITEMS   = 2 * (CMD_BITS + SMP_BITS);  // items per axis transfer
  localparam int SAMPLE_ITEMS = 2 * XFER_ITEMS;             // items per x plus y sample
  localparam int SETTLE_CYCLES = 100;  // covers the two serial map passes of a done item
  localparam int RANDOM_ITEMS = 480;

  // indexes past the register list, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = 3'd7;

  typedef struct {
    logic        cs_n;
    logic        sclk;
    logic        mosi;
    logic        done_res;
    logic [11:0] touch_x;
    logic [11:0] touch_y;
    logic        cal_fault;
  } levels_t;

  logic                 clk_i;
  logic                 rst_ni         = 1'b0;
  logic                 s_axis_tvalid  = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata   = '0;   // start_req, miso, zero fill
  logic                 m_axis_tvalid;
  logic                 m_axis_tready  = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;          // cs_n, sclk, mosi, done_res, touch_x,
                                               // touch_y, cal_fault, zero fill
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [REG_W-1:0]     cfg_data_i     = '0;

  // predicted calibration registers
  logic [11:0] cal_x_min, cal_y_min, cal_x_max, cal_y_max, cal_width, cal_height;

  // predicted sequencer state
  logic                bus_busy;
  logic                clk_high_done;   // 1 once the high half of the current bit is out
  int                  bit_index;
  logic                on_y_axis;
  logic [SMP_BITS-1:0] shift_word;
  logic [11:0]         held_raw_x;
  logic [11:0]         coord_x, coord_y;

  levels_t pending_levels[$];
  int      mismatch_count  = 0;
  int      busy_items_sent = 0;
  bit      steady_input    = 0;   // no gaps from the sender
  bit      steady_output   = 0;   // no stalls from the receiver
  int      stall_request   = 0;   // long receiver hold-off asked by a test
  int      hold_left       = 0;
  int      recv_gap        = 0;

  touch_spi_sampler_calibrated i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // linear map, truncating toward zero, clamped to 0..size; zero span gives 0
  function automatic logic [11:0] scale_axis(logic [11:0] raw, logic [11:0] lo,
                                             logic [11:0] hi, logic [11:0] size);
    int span;
    int scaled;
    span = int'(hi) - int'(lo);
    if (span == 0) return '0;
    scaled = ((int'(raw) - int'(lo)) * int'(size)) / span;
    if (scaled > int'(size)) scaled = int'(size);
    if (scaled < 0) scaled = 0;
    return scaled[11:0];
  endfunction

  // one half period of the serial clock: update state, give pin levels
  function automatic levels_t advance_sampler(logic start, logic miso);
    levels_t          lv;
    logic [CMD_BITS-1:0] cmd;
    lv.cs_n = 1'b1;
    lv.sclk = 1'b0;
    lv.mosi = 1'b0;
    lv.done_res = 1'b0;
    lv.cal_fault = 1'b0;
    // a start only counts while idle; the same item is the first high half
    if (!bus_busy && start) begin
      bus_busy      = 1'b1;
      clk_high_done = 1'b0;
      bit_index     = 0;
      on_y_axis     = 1'b0;
      shift_word    = '0;
    end
    if (bus_busy) begin
      cmd     = on_y_axis ? CMD_Y : CMD_X;
      lv.cs_n = 1'b0;
      if (bit_index < CMD_BITS) lv.mosi = cmd[CMD_BITS-1-bit_index];
      if (!clk_high_done) begin
        lv.sclk = 1'b1;
        if (bit_index >= CMD_BITS) shift_word = {shift_word[SMP_BITS-2:0], miso};
        clk_high_done = 1'b1;
      end else begin
        clk_high_done = 1'b0;
        bit_index++;
        if (bit_index >= CMD_BITS + SMP_BITS) begin
          bit_index = 0;
          if (!on_y_axis) begin
            held_raw_x = shift_word;
            on_y_axis  = 1'b1;
            shift_word = '0;
          end else begin
            coord_x      = scale_axis(held_raw_x, cal_x_min, cal_x_max, cal_width);
            coord_y      = scale_axis(shift_word, cal_y_min, cal_y_max, cal_height);
            lv.cal_fault = (cal_x_min == cal_x_max) || (cal_y_min == cal_y_max);
            lv.done_res  = 1'b1;
            bus_busy     = 1'b0;
            on_y_axis    = 1'b0;
          end
        end
      end
    end
    lv.touch_x = coord_x;
    lv.touch_y = coord_y;
    return lv;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    case (idx)
      REG_X_MIN:  cal_x_min  = val;
      REG_Y_MIN:  cal_y_min  = val;
      REG_X_MAX:  cal_x_max  = val;
      REG_Y_MAX:  cal_y_max  = val;
      REG_WIDTH:  cal_width  = val;
      REG_HEIGHT: cal_height = val;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void compare_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    levels_t got;
    levels_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.cs_n      = m_axis_tdata[OUT_CS];
      got.sclk      = m_axis_tdata[OUT_SCLK];
      got.mosi      = m_axis_tdata[OUT_MOSI];
      got.done_res  = m_axis_tdata[OUT_DONE];
      got.touch_x   = m_axis_tdata[OUT_X_LO +: 12];
      got.touch_y   = m_axis_tdata[OUT_Y_LO +: 12];
      got.cal_fault = m_axis_tdata[OUT_FAULT];
      if (pending_levels.size() == 0) begin
        $display("%0t: result item with none expected, expected none, actual %h",
                 $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_levels.pop_front();
        compare_field("cs_n",      want.cs_n,      got.cs_n);
        compare_field("sclk",      want.sclk,      got.sclk);
        compare_field("mosi",      want.mosi,      got.mosi);
        compare_field("done_res",  want.done_res,  got.done_res);
        compare_field("touch_x",   want.touch_x,   got.touch_x);
        compare_field("touch_y",   want.touch_y,   got.touch_y);
        compare_field("cal_fault", want.cal_fault, got.cal_fault);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // receiver: random stalls, plus the long hold-off a test may ask for
  always @(posedge clk_i) begin
    if (stall_request != 0) begin
      hold_left     = stall_request;
      stall_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!steady_output) recv_gap = pick_gap();
    end
  end

  // offer one item and wait until it is taken; valid stays up for the next one
  task automatic push_item(input logic start, input logic miso);
    int gap;
    gap = steady_input ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, miso, start};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_levels.push_back(advance_sampler(start, miso));
  endtask

  // one full x plus y sample; the converter answers raw_x then raw_y
  task automatic run_sample(input logic [11:0] raw_x, input logic [11:0] raw_y,
                            input int stray_start_pct, input bit start_on_done);
    int   k;
    int   pos;
    int   bit_no;
    logic start;
    logic miso;
    for (k = 0; k < SAMPLE_ITEMS; k++) begin
      pos    = k % XFER_ITEMS;
      bit_no = pos / 2;
      miso   = 1'($urandom_range(0, 1));
      // only the high half of a result bit is sampled
      if (pos % 2 == 0 && bit_no >= CMD_BITS)
        miso = (k < XFER_ITEMS) ? raw_x[SMP_BITS-1-(bit_no-CMD_BITS)]
                                : raw_y[SMP_BITS-1-(bit_no-CMD_BITS)];
      start = (k == 0) || ($urandom_range(0, 99) < stray_start_pct);
      if (k == SAMPLE_ITEMS - 1 && start_on_done) start = 1'b1;
      push_item(start, miso);
    end
    busy_items_sent += SAMPLE_ITEMS;
  endtask

  // drop valid, let every result come back and the map unit go quiet
  task automatic settle_idle();
    while (bus_busy) push_item(1'b0, 1'($urandom_range(0, 1)));
    s_axis_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_register(idx, val);
  endtask

  task automatic write_calibration(input logic [11:0] x_lo, input logic [11:0] y_lo,
                                   input logic [11:0] x_hi, input logic [11:0] y_hi,
                                   input logic [11:0] width, input logic [11:0] height);
    cfg_write(REG_X_MIN,  x_lo);
    cfg_write(REG_Y_MIN,  y_lo);
    cfg_write(REG_X_MAX,  x_hi);
    cfg_write(REG_Y_MAX,  y_hi);
    cfg_write(REG_WIDTH,  width);
    cfg_write(REG_HEIGHT, height);
    cfg_valid_i <= 1'b0;
  endtask

  // raw reading biased toward the edges and the calibration points
  function automatic logic [11:0] pick_raw(logic [11:0] lo, logic [11:0] hi);
    int v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 4095;
      2: v = int'(lo);
      3: v = int'(hi);
      4: v = int'(lo) + $urandom_range(0, 8) - 4;
      5: v = int'(hi) + $urandom_range(0, 8) - 4;
      default: v = $urandom_range(0, 4095);
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  task automatic pick_calibration();
    logic [11:0] xl, yl, xh, yh, w, h;
    xl = 12'($urandom_range(0, 1000));
    yl = 12'($urandom_range(0, 1000));
    xh = 12'($urandom_range(3000, 4095));
    yh = 12'($urandom_range(3000, 4095));
    w  = 12'($urandom_range(1, 4095));
    h  = 12'($urandom_range(1, 4095));
    case ($urandom_range(0, 7))
      0: if ($urandom_range(0, 1)) xh = xl; else yh = yl;   // one span zero
      1: begin                                             // mirrored panel
        xl = 12'($urandom_range(2048, 4095));
        xh = 12'($urandom_range(0, 2047));
        yl = 12'($urandom_range(2048, 4095));
        yh = 12'($urandom_range(0, 2047));
      end
      2: begin                                             // full range
        xl = 0;
        yl = 0;
        xh = 4095;
        yh = 4095;
        w  = 4095;
        h  = 1;
      end
      3: begin                                             // screen size extremes
        w = $urandom_range(0, 1) ? 12'd0 : 12'd4095;
        h = $urandom_range(0, 1) ? 12'd0 : 12'd4095;
      end
      default: ;
    endcase
    write_calibration(xl, yl, xh, yh, w, h);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // idle items after reset: chip select high, clock low, coordinates zero
  task automatic test_idle_after_reset();
    push_item(1'b0, 1'b1);
    push_item(1'b0, 1'b0);
    push_item(1'b0, 1'b1);
  endtask

  // reset calibration, raw extremes, starts while busy and on the done item
  task automatic test_default_calibration();
    run_sample(12'hFFF, 12'h000, 20, 1);
  endtask

  // zero x span, reversed y span, zero width, ignored register indexes,
  // and a restart on the item right after done
  task automatic test_degenerate_spans();
    settle_idle();
    write_calibration(12'hFFF, 12'hFFF, 12'hFFF, 12'h000, 12'h000, 12'hFFF);
    @(posedge clk_i);
    cfg_write(IDX_UNUSED_LO, 12'hABC);
    cfg_write(IDX_UNUSED_HI, 12'h543);
    cfg_valid_i <= 1'b0;
    run_sample(12'h000, 12'h000, 0, 0);
    run_sample(12'hFFF, 12'hFFF, 0, 0);
    run_sample(12'h800, 12'h7FF, 0, 0);
  endtask

  // receiver holds off long while the sender keeps offering items
  task automatic test_backpressure();
    settle_idle();
    write_calibration(12'd200, 12'd300, 12'd3900, 12'd3800, 12'd800, 12'd480);
    steady_input  = 1;
    stall_request = 300;
    run_sample(pick_raw(12'd200, 12'd3900), pick_raw(12'd300, 12'd3800), 5, 0);
    steady_input  = 0;
  endtask

  // random calibrations, raw readings and idle noise between samples
  task automatic test_random_samples();
    busy_items_sent = 0;
    while (busy_items_sent < RANDOM_ITEMS) begin
      settle_idle();
      pick_calibration();
      steady_input  = ($urandom_range(0, 4) == 0);
      steady_output = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 3)) push_item(1'b0, 1'($urandom_range(0, 1)));
        run_sample(pick_raw(cal_x_min, cal_x_max), pick_raw(cal_y_min, cal_y_max),
                   $urandom_range(0, 15), $urandom_range(0, 3) == 0);
      end
    end
    steady_input  = 0;
    steady_output = 0;
  endtask

  task automatic finish_run();
    s_axis_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  endtask

  initial begin
    cal_x_min     = RST_X_MIN;
    cal_y_min     = RST_Y_MIN;
    cal_x_max     = RST_X_MAX;
    cal_y_max     = RST_Y_MAX;
    cal_width     = RST_WIDTH;
    cal_height    = RST_HEIGHT;
    bus_busy      = 1'b0;
    clk_high_done = 1'b0;
    bit_index     = 0;
    on_y_axis     = 1'b0;
    shift_word    = '0;
    held_raw_x    = '0;
    coord_x       = '0;
    coord_y       = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_idle_after_reset();
    test_default_calibration();
    test_degenerate_spans();
    test_backpressure();
    test_random_samples();
    finish_run();
  end

endmodule

/* files.f */
+incdir+rtl
rtl/tsc_pkg.sv
rtl/tsc_seq.sv
rtl/tsc_map.sv
rtl/touch_spi_sampler_calibrated.sv
tb/testbench.sv
